// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the checker file imuv_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, disabled while reset is low.
`define AST_CHECK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	`AST_CHECK(label, clk, rst_n, (ante) |=> (cons))

`endif

// ----- hdl/imuv_pkg.sv -----
package imuv_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int AXES           = 6;
	localparam int LIMIT_BITS     = 40;
	localparam int WINDOW_LEN_DEF = 12;
	localparam int QUEUE_DEPTH    = 4;
	localparam int REG_IDX_W      = 3;

	typedef logic signed [SAMPLE_BITS-1:0] axis_sample_t;
	typedef logic [LIMIT_BITS-1:0] limit_t;

	// One six-axis beat on the input channel.
	typedef struct packed {
		axis_sample_t accel_x;
		axis_sample_t accel_y;
		axis_sample_t accel_z;
		axis_sample_t pitch_rate;
		axis_sample_t roll_rate;
		axis_sample_t yaw_rate;
	} imu_sample_t;

	// One beat on the result channel.
	typedef struct packed {
		logic             moving;
		logic [AXES-1:0]  axis_exceed;
	} motion_result_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_ACCEL_X_LIMIT,
		REG_ACCEL_Y_LIMIT,
		REG_ACCEL_Z_LIMIT,
		REG_PITCH_LIMIT,
		REG_ROLL_LIMIT,
		REG_YAW_LIMIT
	} reg_index_t;

	localparam limit_t LIMIT_RESET [AXES] = '{
		40'd19327352, 40'd48318336, 40'd19327352,
		40'd96636816, 40'd7247808,  40'd7247808
	};

	// Running sum width: sample plus window growth plus a guard bit.
	function automatic int sum_w(int n);
		return SAMPLE_BITS + $clog2(n) + 1;
	endfunction

	// Running sum of squares width (unsigned).
	function automatic int sq_w(int n);
		return 2 * SAMPLE_BITS + $clog2(n);
	endfunction

	// One queue entry: sum and sum of squares for every axis.
	function automatic int entry_w(int n);
		return AXES * (sum_w(n) + sq_w(n));
	endfunction

	function automatic int max3(int a, int b, int c);
		int m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

endpackage

// ----- hdl/imuv_queue.sv -----
module imuv_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_q];

	// Store pushed entries; space is guaranteed by the front's credit count.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

// ----- hdl/imuv_front.sv -----
module imuv_front #(
	parameter int WINDOW_LEN = imuv_pkg::WINDOW_LEN_DEF,
	localparam int EQ_W = imuv_pkg::entry_w(WINDOW_LEN)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  imuv_pkg::imu_sample_t sample,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  logic                  pop,
	output logic                  push,
	output logic [EQ_W-1:0]       push_data
);
	import imuv_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_LEN);
	localparam int CNT_W = $clog2(WINDOW_LEN + 1);
	localparam int CRD_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SUM_W = sum_w(WINDOW_LEN);
	localparam int SQ_W  = sq_w(WINDOW_LEN);
	localparam int EW    = SUM_W + SQ_W;
	localparam int SQ1_W = 2 * SAMPLE_BITS;
	localparam int DS_W  = SAMPLE_BITS + 1;
	localparam int DQ_W  = SQ1_W + 1;

	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] fill_q;
	logic [CRD_W-1:0] credit_q;
	imu_sample_t      ring_mem [WINDOW_LEN];

	logic accept;
	logic fresh_now;
	logic emit_now;

	// Stage 1: new sample, old ring entry, square of the new sample.
	logic             valid_s1;
	logic             fresh_s1;
	logic             emit_s1;
	imu_sample_t      new_s1;
	imu_sample_t      old_s1;
	logic [SQ1_W-1:0] nvsq_s1 [AXES];

	// Stage 2: per-axis deltas to the running sums.
	logic                   valid_s2;
	logic                   emit_s2;
	logic signed [DS_W-1:0] dsum_s2 [AXES];
	logic signed [DQ_W-1:0] dsq_s2 [AXES];

	logic signed [SUM_W-1:0] sum_q [AXES];
	logic [SQ_W-1:0]         sq_q [AXES];
	logic signed [SUM_W-1:0] sum_next [AXES];
	logic [SQ_W-1:0]         sq_next [AXES];

	axis_sample_t            nv [AXES];
	axis_sample_t            nv1 [AXES];
	axis_sample_t            ov1 [AXES];
	logic signed [SQ1_W-1:0] nvx [AXES];
	logic signed [SQ1_W-1:0] ovx [AXES];
	logic [SQ1_W-1:0]        nvsq [AXES];
	logic [SQ1_W-1:0]        ovsq [AXES];

	// Take a beat only while a queue slot is reserved for it.
	assign sample_ready = (credit_q < CRD_W'(QUEUE_DEPTH));
	assign accept       = sample_valid & sample_ready;
	assign fresh_now    = (fill_q < CNT_W'(WINDOW_LEN));
	assign emit_now     = (fill_q >= CNT_W'(WINDOW_LEN - 1));

	// Split beats into axis lanes; unwritten ring entries read as zero.
	always_comb begin
		nv[0] = sample.accel_x;
		nv[1] = sample.accel_y;
		nv[2] = sample.accel_z;
		nv[3] = sample.pitch_rate;
		nv[4] = sample.roll_rate;
		nv[5] = sample.yaw_rate;
		nv1[0] = new_s1.accel_x;
		nv1[1] = new_s1.accel_y;
		nv1[2] = new_s1.accel_z;
		nv1[3] = new_s1.pitch_rate;
		nv1[4] = new_s1.roll_rate;
		nv1[5] = new_s1.yaw_rate;
		ov1[0] = old_s1.accel_x;
		ov1[1] = old_s1.accel_y;
		ov1[2] = old_s1.accel_z;
		ov1[3] = old_s1.pitch_rate;
		ov1[4] = old_s1.roll_rate;
		ov1[5] = old_s1.yaw_rate;
		for (int a = 0; a < AXES; a++) begin
			if (fresh_s1) begin
				ov1[a] = '0;
			end
			nvx[a]  = SQ1_W'(nv[a]);
			ovx[a]  = SQ1_W'(ov1[a]);
			nvsq[a] = $unsigned(nvx[a] * nvx[a]);
			ovsq[a] = $unsigned(ovx[a] * ovx[a]);
		end
	end

	// Ring memory: read the oldest entry and overwrite it in the same beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			old_s1          <= ring_mem[ptr_q];
			ring_mem[ptr_q] <= sample;
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (accept) begin
			new_s1 <= sample;
			for (int a = 0; a < AXES; a++) begin
				nvsq_s1[a] <= nvsq[a];
			end
		end
		if (valid_s1) begin
			for (int a = 0; a < AXES; a++) begin
				dsum_s2[a] <= DS_W'(nv1[a]) - DS_W'(ov1[a]);
				dsq_s2[a]  <= $signed(DQ_W'(nvsq_s1[a]) - DQ_W'(ovsq[a]));
			end
		end
	end

	// Fold deltas into the running sums.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			sum_next[a] = sum_q[a] + SUM_W'(dsum_s2[a]);
			sq_next[a]  = sq_q[a] + SQ_W'(dsq_s2[a]);
			push_data[a*EW +: EW] = {sum_next[a], sq_next[a]};
		end
	end

	assign push = valid_s2 & emit_s2;

	// Control state: pointer, fill level, credits, stage valids, sums.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			fill_q   <= '0;
			credit_q <= '0;
			valid_s1 <= 1'b0;
			fresh_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			emit_s2  <= 1'b0;
			for (int a = 0; a < AXES; a++) begin
				sum_q[a] <= '0;
				sq_q[a]  <= '0;
			end
		end else begin
			if (accept) begin
				ptr_q <= (ptr_q == PTR_W'(WINDOW_LEN - 1)) ? '0 : ptr_q + 1'b1;
				if (fresh_now) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			credit_q <= credit_q + CRD_W'(accept & emit_now) - CRD_W'(pop);
			valid_s1 <= accept;
			fresh_s1 <= fresh_now;
			emit_s1  <= emit_now;
			valid_s2 <= valid_s1;
			emit_s2  <= emit_s1;
			if (valid_s2) begin
				for (int a = 0; a < AXES; a++) begin
					sum_q[a] <= sum_next[a];
					sq_q[a]  <= sq_next[a];
				end
			end
		end
	end

endmodule

// ----- hdl/imuv_back.sv -----
module imuv_back #(
	parameter int WINDOW_LEN = imuv_pkg::WINDOW_LEN_DEF,
	localparam int EQ_W = imuv_pkg::entry_w(WINDOW_LEN)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     head_valid,
	input  logic [EQ_W-1:0]          head_data,
	output logic                     pop,
	input  imuv_pkg::limit_t         limits [imuv_pkg::AXES],
	output imuv_pkg::motion_result_t result,
	output logic                     result_valid,
	input  logic                     result_ready
);
	import imuv_pkg::*;

	localparam int SUM_W  = sum_w(WINDOW_LEN);
	localparam int SQ_W   = sq_w(WINDOW_LEN);
	localparam int EW     = SUM_W + SQ_W;
	localparam int NW     = $clog2(WINDOW_LEN + 1);
	localparam int VAR_W  = SQ_W + NW;
	localparam int MAG2_W = 2 * SUM_W;
	localparam int WIDE_W = max3(VAR_W, MAG2_W, LIMIT_BITS);

	logic signed [SUM_W-1:0] sum_h [AXES];
	logic [SQ_W-1:0]         sq_h [AXES];
	logic [SUM_W-1:0]        mag [AXES];
	logic [VAR_W-1:0]        scaled [AXES];
	logic [MAG2_W-1:0]       mag2 [AXES];

	logic                    valid_b1;
	logic [VAR_W-1:0]        scaled_b1 [AXES];
	logic [MAG2_W-1:0]       mag2_b1 [AXES];

	logic [WIDE_W-1:0]       var_w [AXES];
	logic [AXES-1:0]         exceed;
	logic                    adv_out;
	logic                    take_b1;

	assign adv_out = !result_valid | result_ready;
	assign take_b1 = !valid_b1 | adv_out;
	assign pop     = head_valid & take_b1;

	// Scale the square sum by the window length; square the sum magnitude.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			sum_h[a]  = $signed(head_data[a*EW + SQ_W +: SUM_W]);
			sq_h[a]   = head_data[a*EW +: SQ_W];
			mag[a]    = sum_h[a][SUM_W-1] ? $unsigned(-sum_h[a]) : $unsigned(sum_h[a]);
			scaled[a] = VAR_W'(sq_h[a]) * VAR_W'(WINDOW_LEN);
			mag2[a]   = MAG2_W'(mag[a]) * MAG2_W'(mag[a]);
		end
	end

	// Variance and strict compare against each axis limit.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			var_w[a]  = WIDE_W'(scaled_b1[a]) - WIDE_W'(mag2_b1[a]);
			exceed[a] = (var_w[a] > WIDE_W'(limits[a]));
		end
	end

	// Hold products for the compare stage.
	always_ff @(posedge clk) begin
		if (pop) begin
			for (int a = 0; a < AXES; a++) begin
				scaled_b1[a] <= scaled[a];
				mag2_b1[a]   <= mag2[a];
			end
		end
		if (valid_b1 && adv_out) begin
			result.moving      <= |exceed;
			result.axis_exceed <= exceed;
		end
	end

	// Advance stage valids; hold the output beat while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_b1     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (take_b1) begin
				valid_b1 <= head_valid;
			end
			if (adv_out) begin
				result_valid <= valid_b1;
			end
		end
	end

endmodule

// ----- hdl/imu_window_variance_motion_detect.sv -----
// Throughput: one sample per cycle while a queue credit is free, set by the
// single-port ring memory read and rewritten in the accept cycle; the six
// axis lanes run in parallel. Results are registered at the output.
// The first WINDOW_LEN-1 samples after reset yield no result beat.
// Reset (arst_n low, asynchronous) clears sums, pointers, fill level, queue
// and stage valids, and loads the limit registers with their defaults.
module imu_window_variance_motion_detect #(
	parameter int WINDOW_LEN = imuv_pkg::WINDOW_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  imuv_pkg::imu_sample_t               sample,
	input  logic                                sample_valid,
	output logic                                sample_ready,
	output imuv_pkg::motion_result_t            result,
	output logic                                result_valid,
	input  logic                                result_ready,
	input  logic                                cfg_we,
	input  logic [imuv_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [imuv_pkg::LIMIT_BITS-1:0]     cfg_data
);
	import imuv_pkg::*;

	localparam int EQ_W = entry_w(WINDOW_LEN);

	limit_t           limit_q [AXES];
	logic             push;
	logic [EQ_W-1:0]  push_data;
	logic             pop;
	logic             head_valid;
	logic [EQ_W-1:0]  head_data;

	// Limit registers; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				limit_q[a] <= LIMIT_RESET[a];
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACCEL_X_LIMIT: limit_q[0] <= cfg_data;
				REG_ACCEL_Y_LIMIT: limit_q[1] <= cfg_data;
				REG_ACCEL_Z_LIMIT: limit_q[2] <= cfg_data;
				REG_PITCH_LIMIT:   limit_q[3] <= cfg_data;
				REG_ROLL_LIMIT:    limit_q[4] <= cfg_data;
				REG_YAW_LIMIT:     limit_q[5] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	imuv_front #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.pop          (pop),
		.push         (push),
		.push_data    (push_data)
	);

	imuv_queue #(
		.WIDTH(EQ_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	imuv_back #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head_data    (head_data),
		.pop          (pop),
		.limits       (limit_q),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

// ----- hdl/imuv_checker.sv -----
`include "assert_macros.svh"

module imuv_checker #(
	parameter int WINDOW_LEN = imuv_pkg::WINDOW_LEN_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input imuv_pkg::imu_sample_t           sample,
	input logic                            sample_valid,
	input logic                            sample_ready,
	input imuv_pkg::motion_result_t        result,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic                            cfg_we,
	input logic [imuv_pkg::REG_IDX_W-1:0]  cfg_index,
	input logic [imuv_pkg::LIMIT_BITS-1:0] cfg_data
);
	localparam int CNT_W = $clog2(WINDOW_LEN + 1);

	logic [CNT_W-1:0] seen_q;
	logic             in_beat;
	logic             in_wait;
	logic             out_wait;
	logic             win_full;
	logic             moving_ok;

	assign in_beat   = sample_valid && sample_ready;
	assign in_wait   = sample_valid && !sample_ready;
	assign out_wait  = result_valid && !result_ready;
	assign win_full  = (seen_q == CNT_W'(WINDOW_LEN));
	assign moving_ok = (result.moving == (result.axis_exceed != '0));

	// Count accepted beats since reset, saturating at the window length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (in_beat && !win_full) begin
			seen_q <= seen_q + 1'b1;
		end
	end

	// A stalled result beat holds.
	`AST_NEXT(a_result_hold, clk, arst_n, out_wait, result_valid && $stable(result))

	// A stalled sample beat holds.
	`AST_NEXT(a_sample_hold, clk, arst_n, in_wait, sample_valid && $stable(sample))

	// The summary flag matches the per-axis flags.
	`AST_CHECK(a_moving_flag, clk, arst_n, !result_valid || moving_ok)

	// No result before a full window has been taken.
	`AST_CHECK(a_window_full, clk, arst_n, !result_valid || win_full)

	// Register writes carry a known index and value.
	`AST_CHECK(a_cfg_known, clk, arst_n, !cfg_we || !$isunknown({cfg_index, cfg_data}))

endmodule

bind imu_window_variance_motion_detect imuv_checker #(
	.WINDOW_LEN(WINDOW_LEN)
) u_imuv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample       (sample),
	.sample_valid (sample_valid),
	.sample_ready (sample_ready),
	.result       (result),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.cfg_we       (cfg_we),
	.cfg_index    (cfg_index),
	.cfg_data     (cfg_data)
);

// ----- test/imu_window_variance_motion_detect_tb.sv -----
module imu_window_variance_motion_detect_tb;
	import imuv_pkg::*;

	localparam int WIN            = WINDOW_LEN_DEF;
	localparam int SAMPLE_MAX     = 2 ** (SAMPLE_BITS - 1) - 1;
	localparam int SAMPLE_MIN     = -(2 ** (SAMPLE_BITS - 1));
	localparam int MAX_GAP        = 11;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 200;
	localparam int STALL_ITEMS    = 60;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 205;
	localparam int MAX_REPORTS    = 10;

	// register indexes past the last limit register; writes there are dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam limit_t LIMIT_MAX = '1;

	typedef enum int {BURST_FULL, BURST_NOISE, BURST_FLAT} burst_kind_t;

	logic           clk;
	logic           arst_n       = 1'b0;
	imu_sample_t    sample       = '0;
	logic           sample_valid = 1'b0;
	logic           sample_ready;
	motion_result_t result;
	logic           result_valid;
	logic           result_ready = 1'b0;
	logic           cfg_we       = 1'b0;
	logic [REG_IDX_W-1:0]  cfg_index = '0;
	logic [LIMIT_BITS-1:0] cfg_data  = '0;

	// window shadow: ring, running sums, fill level and write slot
	longint win_ring [WIN][AXES];
	longint win_sum [AXES];
	longint win_sq [AXES];
	int     win_fill;
	int     win_ptr;
	limit_t limit_shadow [AXES];
	motion_result_t expected_motion [$];

	int  mismatches;
	int  stall_cycles;
	bit  src_idle_on;
	bit  sink_idle_on;
	int  sink_hold_cycles;

	burst_kind_t burst_kind;
	int          burst_amp;
	int          burst_base [AXES];

	imu_window_variance_motion_detect #(
		.WINDOW_LEN(WIN)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int axis_of(imu_sample_t s, int a);
		case (a)
			0: return $signed(s.accel_x);
			1: return $signed(s.accel_y);
			2: return $signed(s.accel_z);
			3: return $signed(s.pitch_rate);
			4: return $signed(s.roll_rate);
			default: return $signed(s.yaw_rate);
		endcase
	endfunction

	function automatic imu_sample_t with_axis(imu_sample_t s, int a, int v);
		case (a)
			0: s.accel_x = axis_sample_t'(v);
			1: s.accel_y = axis_sample_t'(v);
			2: s.accel_z = axis_sample_t'(v);
			3: s.pitch_rate = axis_sample_t'(v);
			4: s.roll_rate = axis_sample_t'(v);
			default: s.yaw_rate = axis_sample_t'(v);
		endcase
		return s;
	endfunction

	// N * sum(x^2) - sum(x)^2 over the current window
	function automatic longint scaled_variance(int a);
		return WIN * win_sq[a] - win_sum[a] * win_sum[a];
	endfunction

	// Advance the window by one sample and queue the flags it yields
	function automatic void predict_motion(imu_sample_t s);
		int slot;
		longint nv;
		longint ov;
		motion_result_t r;
		slot = win_ptr;
		for (int a = 0; a < AXES; a++) begin
			nv = axis_of(s, a);
			ov = win_ring[slot][a];
			win_sum[a] += nv - ov;
			win_sq[a] += nv * nv - ov * ov;
			win_ring[slot][a] = nv;
		end
		win_ptr = (slot == WIN - 1) ? 0 : slot + 1;
		if (win_fill < WIN)
			win_fill++;
		if (win_fill == WIN) begin
			r = '0;
			for (int a = 0; a < AXES; a++)
				r.axis_exceed[a] = scaled_variance(a) > longint'(limit_shadow[a]);
			r.moving = |r.axis_exceed;
			expected_motion.push_back(r);
		end
	endfunction

	// Sample that will be overwritten next; resending it keeps the window as is
	function automatic imu_sample_t oldest_sample();
		imu_sample_t s;
		s = '0;
		for (int a = 0; a < AXES; a++)
			s = with_axis(s, a, int'(win_ring[win_ptr][a]));
		return s;
	endfunction

	function automatic int idle_draw(bit on);
		return on ? $urandom_range(0, MAX_GAP) : 0;
	endfunction

	// Log-spread limits so thresholds land across every variance scale
	function automatic limit_t random_limit();
		int pick;
		int width;
		limit_t raw;
		pick = $urandom_range(0, 9);
		width = $urandom_range(1, LIMIT_BITS);
		raw = limit_t'({$urandom, $urandom});
		if (pick == 0)
			return '0;
		if (pick == 1)
			return LIMIT_MAX;
		return raw & (LIMIT_MAX >> (LIMIT_BITS - width));
	endfunction

	// Pick a burst style and return its length
	function automatic int start_burst();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			burst_kind = BURST_FULL;
		else if (pick == 2)
			burst_kind = BURST_FLAT;
		else
			burst_kind = BURST_NOISE;
		burst_amp = (1 << $urandom_range(0, 15)) - 1;
		for (int a = 0; a < AXES; a++)
			burst_base[a] = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
		return $urandom_range(4, 40);
	endfunction

	function automatic imu_sample_t next_burst_sample();
		imu_sample_t s;
		int v;
		s = '0;
		for (int a = 0; a < AXES; a++) begin
			case (burst_kind)
				BURST_FULL: v = int'($urandom_range(0, 65535)) + SAMPLE_MIN;
				BURST_FLAT: v = burst_base[a];
				default: begin
					v = burst_base[a] + int'($urandom_range(0, 2 * burst_amp)) - burst_amp;
					if (v > SAMPLE_MAX)
						v = SAMPLE_MAX;
					if (v < SAMPLE_MIN)
						v = SAMPLE_MIN;
				end
			endcase
			s = with_axis(s, a, v);
		end
		return s;
	endfunction

	function automatic void note_mismatch(string what, int want, int got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
	endfunction

	// Offer one beat, hold it until accepted
	task automatic send_sample(imu_sample_t s);
		int gap;
		gap = idle_draw(src_idle_on);
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= s;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (!(sample_valid && sample_ready));
	endtask

	// Drop valid, drain all pending flags, let non-result samples clear the pipe
	task automatic settle_block();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (expected_motion.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [REG_IDX_W-1:0] idx, limit_t v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < AXES)
			limit_shadow[idx] = v;
		@(posedge clk);
	endtask

	task automatic load_random_limits();
		for (int a = 0; a < AXES; a++)
			write_limit(reg_index_t'(a), random_limit());
	endtask

	// Fill the window from reset with per-axis extremes under default limits
	task automatic test_window_fill();
		int extremes [5] = '{SAMPLE_MAX, SAMPLE_MIN, 0, -1, 1};
		imu_sample_t s;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		for (int k = 0; k < WIN + 2; k++) begin
			s = '0;
			for (int a = 0; a < AXES; a++)
				s = with_axis(s, a, extremes[(k + a) % 5]);
			send_sample(s);
		end
	endtask

	// Zero limits, limits equal to and one below the variance, then all ones
	task automatic test_limit_edges();
		longint v;
		settle_block();
		for (int a = 0; a < AXES; a++)
			write_limit(reg_index_t'(a), '0);
		send_sample(oldest_sample());
		for (int turn = 0; turn < 2; turn++) begin
			settle_block();
			for (int a = 0; a < AXES; a++) begin
				v = scaled_variance(a);
				if ((a % 2) != turn && v > 0)
					v = v - 1;
				write_limit(reg_index_t'(a), limit_t'(v));
			end
			send_sample(oldest_sample());
		end
		settle_block();
		for (int a = 0; a < AXES; a++)
			write_limit(reg_index_t'(a), LIMIT_MAX);
		send_sample(oldest_sample());
	endtask

	// Writes to the spare indexes must not touch any limit
	task automatic test_spare_index();
		settle_block();
		write_limit(REG_SPARE_LO, '0);
		write_limit(REG_SPARE_HI, '0);
		send_sample(oldest_sample());
		send_sample(oldest_sample());
	endtask

	// Hold the result side off while samples keep coming, so input stalls
	task automatic test_result_stall();
		int left;
		settle_block();
		load_random_limits();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		sink_hold_cycles = LONG_HOLD;
		left = 0;
		for (int k = 0; k < STALL_ITEMS; k++) begin
			if (left == 0)
				left = start_burst();
			send_sample(next_burst_sample());
			left--;
		end
	endtask

	// Phases of bursty random samples, fresh limits and idle mix per phase
	task automatic test_random_stream();
		int left;
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			settle_block();
			load_random_limits();
			if (ph == 1) begin
				src_idle_on = 1'b0;
				sink_idle_on = 1'b0;
			end else begin
				src_idle_on = $urandom_range(0, 3) != 0;
				sink_idle_on = $urandom_range(0, 3) != 0;
			end
			left = 0;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (left == 0)
					left = start_burst();
				send_sample(next_burst_sample());
				left--;
			end
		end
	endtask

	// Result side: random stall per beat, plus any long hold-off requested
	initial begin
		int pause;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			pause = idle_draw(sink_idle_on);
			if (sink_hold_cycles > 0) begin
				pause += sink_hold_cycles;
				sink_hold_cycles = 0;
			end
			if (pause > 0) begin
				result_ready <= 1'b0;
				repeat (pause) @(posedge clk);
			end
			result_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(result_valid && result_ready));
		end
	end

	// Predict on every accepted sample beat, compare every accepted result beat
	always @(posedge clk) begin
		motion_result_t want;
		if (arst_n) begin
			if (sample_valid && sample_ready)
				predict_motion(sample);
			if (result_valid && result_ready) begin
				if (expected_motion.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: result beat with nothing expected: moving=%0b axis_exceed=%06b",
							$time, result.moving, result.axis_exceed);
				end else begin
					want = expected_motion.pop_front();
					if (result.moving !== want.moving)
						note_mismatch("moving", want.moving, result.moving);
					if (result.axis_exceed !== want.axis_exceed)
						note_mismatch("axis_exceed", want.axis_exceed, result.axis_exceed);
				end
			end
		end
	end

	// Count cycles with no beat on either side; give up past the limit
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (result_valid && result_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("imu_window_variance_motion_detect regression: fail");
			$finish;
		end
	end

	initial begin
		for (int a = 0; a < AXES; a++)
			limit_shadow[a] = LIMIT_RESET[a];
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_window_fill();
		test_limit_edges();
		test_spare_index();
		test_result_stall();
		test_random_stream();
		settle_block();
		if (mismatches == 0)
			$display("imu_window_variance_motion_detect regression: pass");
		else
			$display("imu_window_variance_motion_detect regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/imuv_pkg.sv
hdl/imuv_queue.sv
hdl/imuv_front.sv
hdl/imuv_back.sv
hdl/imu_window_variance_motion_detect.sv
hdl/imuv_checker.sv
test/imu_window_variance_motion_detect_tb.sv
